// ===== rtl/core/wdm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stereo waveshaper.
package wdm_pkg;

  // Fixed register widths
  localparam int DRIVE_W    = 16;
  localparam int MIX_W      = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_ADDR_W = 2;
  localparam int GAIN_W     = 17;

  // Unity gain in Q4.12 and unity mix in Q1.16
  localparam logic signed [GAIN_W-1:0] GAIN_UNITY = 17'sd4096;
  localparam logic [MIX_W-1:0]         MIX_UNITY  = 17'h10000;

  // Register reset values
  localparam logic signed [DRIVE_W-1:0] DRIVE_RESET = 16'sd0;
  localparam logic [MIX_W-1:0]          MIX_RESET   = 17'h08000;

  typedef enum logic [1:0] {
    MODE_HARD = 2'd0,
    MODE_SOFT = 2'd1,
    MODE_FOLD = 2'd2,
    MODE_PASS = 2'd3
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DRIVE_GAIN = 2'd0,
    CFG_WET_MIX    = 2'd1,
    CFG_SHAPE_MODE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic [MIX_W-1:0]          mix;
    mode_t                     mode;
  } cfg_t;

endpackage

// ===== rtl/core/waveshaper_distortion_mix_top.sv =====
`timescale 1ns / 1ps
// Stereo waveshaper top level: config registers, two lanes, merge stage.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  input    | start, busy        | left_in, right_in
//  result   | done (one cycle)   | left_out, right_out
//  config   | cfg_we             | cfg_addr, cfg_data
//
// One stereo frame is taken every cycle while busy is low. Seven register stages set
// the latency: drive, clip and phase index, square and table read, cube, mode select,
// blend products, then round and saturate. The result strobe and the result registers
// are loaded at the same edge.
// Reset clears the valid pipeline and the result strobe and loads the register
// defaults; busy is high only while reset is held.
// The receiver cannot stall, so nothing ever holds the pipeline.
module waveshaper_distortion_mix_top #(
  parameter int SAMPLE_BITS      = 24,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [SAMPLE_BITS-1:0]        left_in,
  input  logic signed [SAMPLE_BITS-1:0]        right_in,
  output logic                                 done,
  output logic signed [SAMPLE_BITS-1:0]        left_out,
  output logic signed [SAMPLE_BITS-1:0]        right_out,
  input  logic                                 cfg_we,
  input  logic [wdm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [wdm_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import wdm_pkg::*;

  localparam int LANE_LAT = 6;

  logic                      accept;
  logic [LANE_LAT-1:0]       vld;
  logic signed [DRIVE_W-1:0] drive_gain;
  logic [MIX_W-1:0]          wet_mix;
  mode_t                     shape_mode;
  cfg_t                      cfg;

  logic signed [SAMPLE_BITS+22:0] left_wet;
  logic signed [SAMPLE_BITS+17:0] left_dry;
  logic signed [SAMPLE_BITS+22:0] right_wet;
  logic signed [SAMPLE_BITS+17:0] right_dry;

  assign busy   = rst;
  assign accept = start && !busy;

  // Write config registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain <= DRIVE_RESET;
      wet_mix    <= MIX_RESET;
      shape_mode <= MODE_HARD;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DRIVE_GAIN: drive_gain <= signed'(cfg_data[DRIVE_W-1:0]);
        CFG_WET_MIX:    wet_mix    <= cfg_data[MIX_W-1:0];
        CFG_SHAPE_MODE: shape_mode <= mode_t'(cfg_data[1:0]);
        default:        ;
      endcase
    end
  end

  assign cfg = '{drive: drive_gain, mix: wet_mix, mode: shape_mode};

  // Advance the item valid flags alongside the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LANE_LAT-2:0], accept};
    end
  end

  wdm_lane #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lane_left (
    .clk      (clk),
    .cfg      (cfg),
    .x        (left_in),
    .wet_prod (left_wet),
    .dry_prod (left_dry)
  );

  wdm_lane #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lane_right (
    .clk      (clk),
    .cfg      (cfg),
    .x        (right_in),
    .wet_prod (right_wet),
    .dry_prod (right_dry)
  );

  wdm_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .vld       (vld[LANE_LAT-1]),
    .left_wet  (left_wet),
    .left_dry  (left_dry),
    .right_wet (right_wet),
    .right_dry (right_dry),
    .done      (done),
    .left_out  (left_out),
    .right_out (right_out)
  );

`ifndef SYNTH
  // Every taken item yields its result after the fixed latency
  a_item_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##7 done)
    else $error("item taken but no result strobe after 7 cycles");

  // No result strobe without a matching item taken before it
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 7))
    else $error("result strobe without a matching item");
`endif

endmodule

// ===== rtl/core/wdm_lane.sv =====
`timescale 1ns / 1ps
// One channel lane: drive, shape, and the two blend products.
module wdm_lane #(
  parameter int SAMPLE_BITS      = 24,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  wdm_pkg::cfg_t                 cfg,
  input  logic signed [SAMPLE_BITS-1:0] x,
  output logic signed [SAMPLE_BITS+22:0] wet_prod,
  output logic signed [SAMPLE_BITS+17:0] dry_prod
);
  import wdm_pkg::*;

  localparam int FB = SAMPLE_BITS - 1;
  localparam int TW = SAMPLE_BITS + 5;
  localparam int CW = SAMPLE_BITS + 1;
  localparam int AW = $clog2(SINE_TABLE_DEPTH);
  localparam int DB = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW = FB + DB;

  localparam logic signed [TW-1:0] T_POS = TW'(64'sd1 <<< FB);
  localparam logic signed [TW-1:0] T_NEG = -T_POS;

  // Quarter-wave sine coefficients, Q.30
  localparam longint K_C1  = 64'sd1686629713;
  localparam longint K_C3  = 64'sd693598668;
  localparam longint K_C5  = 64'sd85569306;
  localparam longint K_C7  = 64'sd5026995;
  localparam longint K_C9  = 64'sd172271;
  localparam longint K_C11 = 64'sd3864;
  localparam longint Q30_ONE = 64'sd1 <<< 30;

  typedef logic signed [CW-1:0] rom_t [SINE_TABLE_DEPTH];

  // sin(u*pi/2) for u in Q.30, odd polynomial by Horner's rule
  function automatic longint quarter_sine(input longint u);
    longint s;
    longint acc;
    s   = (u * u) >>> 30;
    acc = -K_C11;
    acc = K_C9 + ((acc * s) >>> 30);
    acc = -K_C7 + ((acc * s) >>> 30);
    acc = K_C5 + ((acc * s) >>> 30);
    acc = -K_C3 + ((acc * s) >>> 30);
    acc = K_C1 + ((acc * s) >>> 30);
    return (acc * u) >>> 30;
  endfunction

  // Full sine period, built at elaboration
  function automatic rom_t build_rom();
    rom_t   rom;
    longint k4;
    longint q;
    longint r;
    longint u;
    longint y;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      k4 = 64'sd4 * longint'(k);
      q  = (k4 / SINE_TABLE_DEPTH) & 64'sd3;
      r  = k4 % SINE_TABLE_DEPTH;
      u  = (r <<< 30) / SINE_TABLE_DEPTH;
      if (q[0]) begin
        u = Q30_ONE - u;
      end
      y = quarter_sine(u);
      if (FB < 30) begin
        y = (y + (64'sd1 <<< (29 - FB))) >>> (30 - FB);
      end else if (FB > 30) begin
        y = y <<< (FB - 30);
      end
      if (q[1]) begin
        y = -y;
      end
      rom[k] = CW'(y);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Stage 1: drive
  logic signed [GAIN_W-1:0]        gain;
  logic signed [SAMPLE_BITS+16:0]  drv_prod;
  logic signed [SAMPLE_BITS-1:0]   x1;
  logic signed [TW-1:0]            t1;

  assign gain     = GAIN_UNITY + GAIN_W'(cfg.drive);
  assign drv_prod = x * gain;

  always_ff @(posedge clk) begin
    x1 <= x;
    t1 <= drv_prod[SAMPLE_BITS+16:12];
  end

  // Stage 2: clip and sine phase index
  logic signed [TW-1:0]          clip;
  logic [PW-1:0]                 idx_prod;
  logic signed [SAMPLE_BITS-1:0] x2;
  logic signed [TW-1:0]          t2;
  logic signed [CW-1:0]          c2;
  logic [AW-1:0]                 idx2;

  assign clip     = (t1 > T_POS) ? T_POS : ((t1 < T_NEG) ? T_NEG : t1);
  assign idx_prod = PW'(t1[FB-1:0]) * PW'(SINE_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    x2   <= x1;
    t2   <= t1;
    c2   <= clip[CW-1:0];
    idx2 <= idx_prod[FB+AW-1:FB];
  end

  // Stage 3: square and table read
  logic signed [2*CW-1:0]        sq_prod;
  logic signed [SAMPLE_BITS-1:0] x3;
  logic signed [TW-1:0]          t3;
  logic signed [CW-1:0]          c3;
  logic signed [CW-1:0]          sq3;
  logic signed [CW-1:0]          sine3;

  assign sq_prod = c2 * c2;

  always_ff @(posedge clk) begin
    x3    <= x2;
    t3    <= t2;
    c3    <= c2;
    sq3   <= sq_prod[FB+CW-1:FB];
    sine3 <= SINE_ROM[idx2];
  end

  // Stage 4: cube
  logic signed [2*CW-1:0]        cube_prod;
  logic signed [SAMPLE_BITS-1:0] x4;
  logic signed [TW-1:0]          t4;
  logic signed [CW-1:0]          c4;
  logic signed [CW-1:0]          cube4;
  logic signed [CW-1:0]          sine4;

  assign cube_prod = sq3 * c3;

  always_ff @(posedge clk) begin
    x4    <= x3;
    t4    <= t3;
    c4    <= c3;
    cube4 <= cube_prod[FB+CW-1:FB];
    sine4 <= sine3;
  end

  // Stage 5: pick the shaped value by mode
  logic signed [CW+1:0]          c_ext;
  logic signed [CW+1:0]          cube_ext;
  logic signed [CW+1:0]          soft_sum;
  logic signed [CW+1:0]          soft_val;
  logic signed [TW-1:0]          shaped;
  logic signed [SAMPLE_BITS-1:0] x5;
  logic signed [TW-1:0]          wet5;

  assign c_ext    = (CW+2)'(c4);
  assign cube_ext = (CW+2)'(cube4);
  assign soft_sum = c_ext + (c_ext <<< 1) - cube_ext;
  assign soft_val = soft_sum >>> 1;

  always_comb begin
    case (cfg.mode)
      MODE_HARD: shaped = TW'(c4);
      MODE_SOFT: shaped = TW'(soft_val);
      MODE_FOLD: shaped = TW'(sine4);
      MODE_PASS: shaped = t4;
      default:   shaped = t4;
    endcase
  end

  always_ff @(posedge clk) begin
    x5   <= x4;
    wet5 <= shaped;
  end

  // Stage 6: blend products, mix limited to unity
  logic [MIX_W-1:0]     mix_eff;
  logic signed [MIX_W:0] mix_wet;
  logic signed [MIX_W:0] mix_dry;

  assign mix_eff = cfg.mix[MIX_W-1] ? MIX_UNITY : cfg.mix;
  assign mix_wet = signed'({1'b0, mix_eff});
  assign mix_dry = signed'({1'b0, MIX_UNITY}) - mix_wet;

  always_ff @(posedge clk) begin
    wet_prod <= mix_wet * wet5;
    dry_prod <= mix_dry * x5;
  end

endmodule

// ===== rtl/core/wdm_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: sum, round and saturate both lanes into the result registers.
module wdm_merge #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           vld,
  input  logic signed [SAMPLE_BITS+22:0] left_wet,
  input  logic signed [SAMPLE_BITS+17:0] left_dry,
  input  logic signed [SAMPLE_BITS+22:0] right_wet,
  input  logic signed [SAMPLE_BITS+17:0] right_dry,
  output logic                           done,
  output logic signed [SAMPLE_BITS-1:0]  left_out,
  output logic signed [SAMPLE_BITS-1:0]  right_out
);
  import wdm_pkg::*;

  localparam int FB = SAMPLE_BITS - 1;
  localparam int SW = SAMPLE_BITS + 24;
  localparam int OW = SAMPLE_BITS + 8;

  localparam logic signed [SW-1:0] ROUND = SW'(64'sd32768);
  localparam logic signed [OW-1:0] O_MAX = OW'((64'sd1 <<< FB) - 64'sd1);
  localparam logic signed [OW-1:0] O_MIN = OW'(-(64'sd1 <<< FB));

  // Round to Q1.23 and saturate one channel
  function automatic logic signed [SAMPLE_BITS-1:0] blend(
    input logic signed [SAMPLE_BITS+22:0] wet,
    input logic signed [SAMPLE_BITS+17:0] dry
  );
    logic signed [SW-1:0] sum;
    logic signed [OW-1:0] o;
    sum = SW'(wet) + SW'(dry) + ROUND;
    o   = sum[SW-1:16];
    if (o > O_MAX) begin
      o = O_MAX;
    end else if (o < O_MIN) begin
      o = O_MIN;
    end
    return o[SAMPLE_BITS-1:0];
  endfunction

  // Strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    left_out  <= blend(left_wet, left_dry);
    right_out <= blend(right_wet, right_dry);
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the stereo waveshaper: directed and random frames.
module tb_top;
  import wdm_pkg::*;

  localparam int SAMPLE_W    = 24;
  localparam int FRAC        = SAMPLE_W - 1;
  localparam int SINE_DEPTH  = 1024;
  localparam int LATENCY     = 7;
  localparam int MAX_REPORTS = 40;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 50;

  // Odd polynomial for sin(u*pi/2), Q.30
  localparam longint SIN_C1  = 64'sd1686629713;
  localparam longint SIN_C3  = 64'sd693598668;
  localparam longint SIN_C5  = 64'sd85569306;
  localparam longint SIN_C7  = 64'sd5026995;
  localparam longint SIN_C9  = 64'sd172271;
  localparam longint SIN_C11 = 64'sd3864;
  localparam longint Q30_ONE = 64'sd1 << 30;

  // The one register index the block does not decode
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [SAMPLE_W-1:0] left_in = '0;
  logic signed [SAMPLE_W-1:0] right_in = '0;
  logic done;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's registers
  logic signed [DRIVE_W-1:0] drive_reg = DRIVE_RESET;
  logic [MIX_W-1:0] wet_reg = MIX_RESET;
  mode_t mode_reg = MODE_HARD;

  frame_t frames_to_send[$];
  frame_t frames_awaited[$];
  int idle_pct = 10;
  int fail_count = 0;

  waveshaper_distortion_mix_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .left_in   (left_in),
    .right_in  (right_in),
    .done      (done),
    .left_out  (left_out),
    .right_out (right_out),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // sin(u*pi/2) in Q.30 by Horner's rule, floored at each step
  function automatic longint quarter_sine_q30(input longint u);
    longint s;
    longint acc;
    s = (u * u) >>> 30;
    acc = -SIN_C11;
    acc = SIN_C9 + ((acc * s) >>> 30);
    acc = -SIN_C7 + ((acc * s) >>> 30);
    acc = SIN_C5 + ((acc * s) >>> 30);
    acc = -SIN_C3 + ((acc * s) >>> 30);
    acc = SIN_C1 + ((acc * s) >>> 30);
    return (acc * u) >>> 30;
  endfunction

  // Sine table entry k, rounded half up to the sample format
  function automatic longint sine_fold_entry(input int unsigned k);
    int unsigned q;
    int unsigned r;
    longint u;
    longint y;
    q = ((4 * k) / SINE_DEPTH) & 3;
    r = (4 * k) % SINE_DEPTH;
    u = (longint'(r) << 30) / SINE_DEPTH;
    if (q[0]) u = Q30_ONE - u;
    y = quarter_sine_q30(u);
    y = (y + (longint'(1) << (29 - FRAC))) >>> (30 - FRAC);
    if (q[1]) y = -y;
    return y;
  endfunction

  // Drive, shape and blend one sample under the shadow registers
  function automatic logic signed [SAMPLE_W-1:0] shape_channel(
    input logic signed [SAMPLE_W-1:0] sample
  );
    longint one;
    longint x;
    longint t;
    longint m;
    longint c3;
    longint o;
    one = longint'(1) << FRAC;
    x = longint'(sample);
    t = (x * (longint'(GAIN_UNITY) + longint'(drive_reg))) >>> 12;
    m = longint'(wet_reg);
    if (m > longint'(MIX_UNITY)) m = longint'(MIX_UNITY);
    case (mode_reg)
      MODE_HARD, MODE_SOFT: begin
        if (t > one) t = one;
        if (t < -one) t = -one;
        if (mode_reg == MODE_SOFT) begin
          c3 = (((t * t) >>> FRAC) * t) >>> FRAC;
          t = (3 * t - c3) >>> 1;
        end
      end
      MODE_FOLD: begin
        t = sine_fold_entry(int'(((t & (one - 1)) * SINE_DEPTH) >> FRAC));
      end
      default: ;
    endcase
    o = (m * t + (longint'(MIX_UNITY) - m) * x + 32768) >>> 16;
    if (o > one - 1) o = one - 1;
    if (o < -one) o = -one;
    return o[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 4095)) - 2048;
      1: v = (($urandom_range(0, 1) != 0) ? 4194304 : -4194304)
             + int'($urandom_range(0, 8191)) - 4096;
      default: v = int'($urandom);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // Send items: predict on acceptance, then present the next one or idle
  always @(posedge clk) begin
    frame_t want;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        want.left = shape_channel(left_in);
        want.right = shape_channel(right_in);
        frames_awaited.push_back(want);
        void'(frames_to_send.pop_front());
      end
      if (!(start && busy)) begin
        if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          left_in <= frames_to_send[0].left;
          right_in <= frames_to_send[0].right;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    frame_t want;
    if (!rst && done) begin
      if (frames_awaited.size() == 0) begin
        if (fail_count < MAX_REPORTS) $error("result with no item outstanding");
        fail_count++;
      end else begin
        want = frames_awaited.pop_front();
        if (left_out !== want.left) begin
          if (fail_count < MAX_REPORTS)
            $error("left_out: expected %0d, got %0d", want.left, left_out);
          fail_count++;
        end
        if (right_out !== want.right) begin
          if (fail_count < MAX_REPORTS)
            $error("right_out: expected %0d, got %0d", want.right, right_out);
          fail_count++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    case (idx)
      CFG_DRIVE_GAIN: drive_reg = value[DRIVE_W-1:0];
      CFG_WET_MIX:    wet_reg = value;
      CFG_SHAPE_MODE: mode_reg = mode_t'(value[1:0]);
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every item is accepted and answered, then let the pipe settle
  task automatic drain();
    while (frames_to_send.size() != 0 || frames_awaited.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic queue_frame(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
    frame_t f;
    f.left = l;
    f.right = r;
    frames_to_send.push_back(f);
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] edge_samples[6];
    int drive_v;
    int wet_v;
    int mode_v;
    edge_samples = '{24'sd0, 24'sh7FFFFF, 24'sh800000, -24'sd1, 24'sd2097152, 24'sd4194304};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: clipping both ways, soft clip, sine fold, then negative drive,
    // wet above one and the unshaped mode; an undecoded index in between
    for (int mode = MODE_HARD; mode <= MODE_PASS; mode++) begin
      drain();
      case (mode_t'(mode))
        MODE_HARD, MODE_SOFT: drive_v = 4096;
        MODE_FOLD:            drive_v = 0;
        default:              drive_v = -32768;
      endcase
      write_reg(CFG_DRIVE_GAIN, CFG_DATA_W'(drive_v));
      write_reg(CFG_WET_MIX, (mode_t'(mode) == MODE_PASS) ? 17'h1FFFF : MIX_UNITY);
      write_reg(CFG_SHAPE_MODE, CFG_DATA_W'(mode));
      write_reg(CFG_UNUSED, 17'h1FFFF);
      end_writes();
      for (int i = 0; i < 6; i++) queue_frame(edge_samples[i], edge_samples[(i + 3) % 6]);
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain();
      idle_pct = (p < 4) ? 10 : (p < 8) ? 76 : 0;
      case (p)
        0: begin drive_v = 32767; wet_v = 0; end
        1: begin drive_v = -4096; wet_v = int'(MIX_UNITY); end
        2: begin drive_v = 24576; wet_v = 131071; end
        default: begin
          if ($urandom_range(0, 3) == 0) drive_v = int'($urandom);
          else drive_v = int'($urandom_range(0, 28672)) - 4096;
          if ($urandom_range(0, 3) == 0) wet_v = int'($urandom_range(0, 131071));
          else wet_v = int'($urandom_range(0, MIX_UNITY));
        end
      endcase
      mode_v = (p < 4) ? p : int'($urandom_range(MODE_HARD, MODE_PASS));
      // Random upper bits must not leak into the narrower registers
      write_reg(CFG_DRIVE_GAIN,
                CFG_DATA_W'(drive_v) | (CFG_DATA_W'($urandom) & 17'h10000));
      write_reg(CFG_WET_MIX, CFG_DATA_W'(wet_v));
      write_reg(CFG_SHAPE_MODE,
                (CFG_DATA_W'($urandom) & 17'h1FFFC) | CFG_DATA_W'(mode_v));
      if ($urandom_range(0, 1) != 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      end_writes();
      for (int i = 0; i < PHASE_ITEMS; i++) queue_frame(random_sample(), random_sample());
    end

    drain();
    repeat (3 * LATENCY) @(posedge clk);
    if (fail_count == 0 && frames_awaited.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #200000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wdm_pkg.sv
rtl/core/wdm_lane.sv
rtl/core/wdm_merge.sv
rtl/core/waveshaper_distortion_mix_top.sv
tb/tb_top.sv
